FILE: sv/fdc_regs_pkg.sv
// Shared types, codes and helpers for the floppy controller register block.
`default_nettype none

package fdc_regs_pkg;

  localparam int BUFFER_BYTES = 128;
  localparam int IDX_W = $clog2(BUFFER_BYTES);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    REQ_BUS_READ  = 2'd0,
    REQ_BUS_WRITE = 2'd1,
    REQ_DISK_PUT  = 2'd2,
    REQ_DISK_GET  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    CMD_FILL       = 3'd0,
    CMD_DRAIN      = 3'd1,
    CMD_WRITE      = 3'd2,
    CMD_READ       = 3'd3,
    CMD_FORMAT     = 3'd4,
    CMD_STATUS     = 3'd5,
    CMD_WRITE_MARK = 3'd6,
    CMD_ERROR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    SREQ_NONE  = 2'd0,
    SREQ_READ  = 2'd1,
    SREQ_WRITE = 2'd2
  } sreq_t;

  localparam logic REG_CMD  = 1'b0;
  localparam logic REG_DATA = 1'b1;

  localparam logic [3:0] ERR_NOT_FOUND  = 4'd7;
  localparam logic [7:0] STATUS_NO_MEDIA = 8'h80;
  localparam logic [7:0] BOOT_TRACK     = 8'd1;
  localparam logic [7:0] BOOT_SECTOR    = 8'd1;

  typedef struct packed {
    logic       en;
    idx_t       addr;
    logic [7:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } buf_rd_t;

  function automatic idx_t idx_next(input idx_t idx);
    idx_t r;
    if (idx == idx_t'(BUFFER_BYTES - 1)) begin
      r = '0;
    end else begin
      r = idx + idx_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/floppy_controller_registers_core.sv
// Top level of the two-register floppy controller with its sector buffer.
//
// The block stalls its input until each word is done. First the sector
// buffer is read at the host or disk index, and after that the controller
// state is updated, the buffer is written back and the result word is loaded
// into the output register. A result waiting in the output register does not
// block acceptance of the next word; the update cycle waits only while that
// register is still full and stalled. The buffer reads as zeros after reset
// through a written flag per entry, so no clearing pass is needed.
`default_nettype none

module floppy_controller_registers_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic       reg_select,
  input  logic [7:0] data_in,
  input  logic [1:0] drive_loaded,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       motor_stop,
  output logic       drive_select,
  output logic [1:0] sector_request,
  output logic [7:0] req_track,
  output logic [7:0] req_sector
);
  import fdc_regs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t     state;
  req_type_t  it_type;
  logic       it_reg;
  logic [7:0] it_value;
  logic [1:0] it_loaded;

  idx_t       host_index, host_index_next;
  idx_t       disk_index, disk_index_next;
  cmd_t       command, command_next;
  logic [1:0] param_count, param_count_next;
  logic [7:0] param_sector, param_sector_next;
  logic       xfer, xfer_next;
  logic       irq_en, irq_en_next;
  logic       err_valid, err_valid_next;
  logic [3:0] err_code, err_code_next;
  logic       done, done_next;
  logic       drive, drive_next;
  logic [7:0] latch, latch_next;
  logic       motor, motor_next;

  logic [7:0] rd_res;
  sreq_t      sreq_res;
  logic [7:0] trk_res;
  logic [7:0] sec_res;

  buf_wr_t    buf_wr;
  buf_rd_t    buf_rd;
  logic [7:0] buf_q;

  logic       accept;
  logic       commit;
  logic       media_cur;
  logic       media_new;
  cmd_t       cmd_in;
  sreq_t      sreq_r;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == ST_EXEC) && (!out_valid || !out_stall);

  assign buf_rd.en   = accept;
  assign buf_rd.addr = (req_type == REQ_DISK_GET) ? disk_index : host_index;

  fdc_regs_buf u_buf (
    .clk     (clk),
    .rst     (rst),
    .wr      (buf_wr),
    .rd      (buf_rd),
    .rd_data (buf_q)
  );

  assign media_cur = it_loaded[drive];
  assign media_new = it_loaded[it_value[4]];
  assign cmd_in    = cmd_t'(it_value[3:1]);

  always_comb begin
    host_index_next   = host_index;
    disk_index_next   = disk_index;
    command_next      = command;
    param_count_next  = param_count;
    param_sector_next = param_sector;
    xfer_next         = xfer;
    irq_en_next       = irq_en;
    err_valid_next    = err_valid;
    err_code_next     = err_code;
    done_next         = done;
    drive_next        = drive;
    latch_next        = latch;
    motor_next        = motor;
    rd_res            = 8'd0;
    sreq_res          = SREQ_NONE;
    trk_res           = 8'd0;
    sec_res           = 8'd0;
    buf_wr.en         = 1'b0;
    buf_wr.addr       = disk_index;
    buf_wr.data       = it_value;

    case (it_type)
      REQ_BUS_READ: begin
        if (it_reg == REG_CMD) begin
          rd_res = {xfer, irq_en, err_valid, done, err_valid ? err_code : 4'd0};
        end else begin
          if (command == CMD_DRAIN) begin
            latch_next      = buf_q;
            host_index_next = idx_next(host_index);
          end
          if (command == CMD_ERROR) begin
            latch_next     = {4'd0, err_valid ? err_code : 4'd0};
            err_valid_next = 1'b0;
            err_code_next  = 4'd0;
            done_next      = 1'b1;
          end
          rd_res = latch_next;
        end
      end
      REQ_BUS_WRITE: begin
        if (it_reg == REG_CMD) begin
          if (it_value[7]) begin
            irq_en_next     = 1'b0;
            drive_next      = 1'b0;
            command_next    = CMD_FILL;
            xfer_next       = 1'b0;
            err_valid_next  = 1'b0;
            err_code_next   = 4'd0;
            motor_next      = 1'b1;
            host_index_next = '0;
            done_next       = 1'b1;
            if (it_loaded[0]) begin
              sreq_res        = SREQ_READ;
              trk_res         = BOOT_TRACK;
              sec_res         = BOOT_SECTOR;
              disk_index_next = '0;
            end
          end else begin
            irq_en_next  = it_value[6];
            drive_next   = it_value[4];
            command_next = cmd_in;
            done_next    = 1'b0;
            if (it_value[0]) begin
              case (cmd_in)
                CMD_FILL, CMD_DRAIN: begin
                  host_index_next = '0;
                  xfer_next       = 1'b1;
                  done_next       = 1'b1;
                  if (!media_new) begin
                    err_valid_next = 1'b1;
                    err_code_next  = ERR_NOT_FOUND;
                  end
                end
                CMD_FORMAT: begin
                  done_next = 1'b1;
                  if (!media_new) begin
                    err_valid_next = 1'b1;
                    err_code_next  = ERR_NOT_FOUND;
                  end
                end
                CMD_READ, CMD_WRITE, CMD_WRITE_MARK: begin
                  param_count_next = 2'd0;
                  xfer_next        = 1'b1;
                  motor_next       = 1'b0;
                end
                CMD_STATUS: begin
                  latch_next = media_new ? 8'd0 : STATUS_NO_MEDIA;
                  done_next  = 1'b1;
                end
                default: begin
                  xfer_next = 1'b1;
                  done_next = 1'b0;
                end
              endcase
            end
          end
        end else begin
          latch_next = it_value;
          if (command == CMD_FILL) begin
            buf_wr.en       = commit;
            buf_wr.addr     = host_index;
            host_index_next = idx_next(host_index);
          end else if (command == CMD_READ || command == CMD_WRITE ||
                       command == CMD_WRITE_MARK) begin
            if (param_count == 2'd0) begin
              param_sector_next = it_value;
              param_count_next  = 2'd1;
            end else if (param_count == 2'd1) begin
              param_count_next = 2'd2;
              done_next        = 1'b1;
              xfer_next        = 1'b0;
              motor_next       = 1'b1;
              if (media_cur) begin
                sreq_res        = (command == CMD_READ) ? SREQ_READ : SREQ_WRITE;
                sec_res         = param_sector;
                trk_res         = it_value;
                disk_index_next = '0;
                host_index_next = '0;
              end else begin
                err_valid_next = 1'b1;
                err_code_next  = ERR_NOT_FOUND;
              end
            end
          end
        end
      end
      REQ_DISK_PUT: begin
        buf_wr.en       = commit;
        disk_index_next = idx_next(disk_index);
      end
      REQ_DISK_GET: begin
        rd_res          = buf_q;
        disk_index_next = idx_next(disk_index);
      end
      default: begin
        rd_res = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      host_index   <= '0;
      disk_index   <= '0;
      command      <= CMD_FILL;
      param_count  <= 2'd0;
      param_sector <= 8'd0;
      xfer         <= 1'b0;
      irq_en       <= 1'b0;
      err_valid    <= 1'b0;
      err_code     <= 4'd0;
      done         <= 1'b0;
      drive        <= 1'b0;
      latch        <= 8'd0;
      motor        <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state        <= ST_IDLE;
            out_valid    <= 1'b1;
            host_index   <= host_index_next;
            disk_index   <= disk_index_next;
            command      <= command_next;
            param_count  <= param_count_next;
            param_sector <= param_sector_next;
            xfer         <= xfer_next;
            irq_en       <= irq_en_next;
            err_valid    <= err_valid_next;
            err_code     <= err_code_next;
            done         <= done_next;
            drive        <= drive_next;
            latch        <= latch_next;
            motor        <= motor_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_type   <= req_type_t'(req_type);
      it_reg    <= reg_select;
      it_value  <= data_in;
      it_loaded <= drive_loaded;
    end
    if (commit) begin
      read_data    <= rd_res;
      motor_stop   <= motor_next;
      drive_select <= drive_next;
      sreq_r       <= sreq_res;
      req_track    <= trk_res;
      req_sector   <= sec_res;
    end
  end

  assign sector_request = sreq_r;

`ifndef SYNTH
  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("A second word was accepted while one was still in flight.");

  a_request_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector_request == SREQ_NONE || sector_request == SREQ_READ ||
                   sector_request == SREQ_WRITE))
    else $error("The sector request code is out of range.");

  a_idle_request_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sector_request == SREQ_NONE) |-> (req_track == 8'd0 && req_sector == 8'd0))
    else $error("Track or sector is nonzero without a sector request.");
`endif

endmodule

`default_nettype wire

FILE: sv/fdc_regs_buf.sv
// Sector buffer memory with one write port, one registered read port and per-entry written flags.
`default_nettype none

module fdc_regs_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  fdc_regs_pkg::buf_wr_t wr,
  input  fdc_regs_pkg::buf_rd_t rd,
  output logic [7:0]            rd_data
);
  import fdc_regs_pkg::*;

  logic [7:0]              mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] written;
  logic [7:0]              q;
  logic                    q_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      q_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        q_valid <= written[rd.addr];
      end
    end
  end

  assign rd_data = q_valid ? q : 8'd0;

endmodule

`default_nettype wire
